### src/dsabt_pkg.sv
// Shared types and constants for the data/strobe/acknowledge bus word transceiver.
// No dependencies; used by dsabt_fsm, the top level and the checker.
package dsabt_pkg;

  // Request fields: one pin-sample tick plus an optional start command
  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] tx_message;
    logic        data_pin;
    logic        strobe_pin;
    logic        ack_pin;
  } in_t;

  // Result fields: line drive, progress and received word
  typedef struct packed {
    logic        data_enable;
    logic        data_level;
    logic        strobe_enable;
    logic        strobe_level;
    logic        ack_enable;
    logic        ack_level;
    logic        busy_res;
    logic        done_res;
    logic [1:0]  status;
    logic [15:0] rx_message;
  } out_t;

  // Configuration register indexes and widths
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 24;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FAIL_WORD     = 1'd1;

  localparam logic [23:0] TIMEOUT_RESET = 24'd250;
  localparam logic [15:0] INVALID_RESET = 16'hFFFF;
  localparam logic [15:0] WORD_MSB      = 16'h8000;

  // Action codes
  localparam logic [1:0] ACT_TICK = 2'd0;
  localparam logic [1:0] ACT_RX   = 2'd1;
  localparam logic [1:0] ACT_TX   = 2'd2;

  // Transfer status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_TIMEOUT = 2'd1;
  localparam logic [1:0] ST_ERR     = 2'd2;

  // Protocol phases
  localparam logic [3:0] PH_IDLE    = 4'd0;
  localparam logic [3:0] PH_R_SYNC  = 4'd1;
  localparam logic [3:0] PH_R_BFALL = 4'd2;
  localparam logic [3:0] PH_R_BRISE = 4'd3;
  localparam logic [3:0] PH_R_AFALL = 4'd4;
  localparam logic [3:0] PH_R_ARISE = 4'd5;
  localparam logic [3:0] PH_T_SFALL = 4'd6;
  localparam logic [3:0] PH_T_SRISE = 4'd7;
  localparam logic [3:0] PH_T_BFALL = 4'd8;
  localparam logic [3:0] PH_T_BRISE = 4'd9;
  localparam logic [3:0] PH_T_AFALL = 4'd10;
  localparam logic [3:0] PH_T_ARISE = 4'd11;

endpackage

### src/dsabt_fsm.sv
// Bus handshake sequencer: phase, bit counter, shift word, phase timeout and line drive.
// Depends on dsabt_pkg; advances one step per accepted request.
module dsabt_fsm (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  dsabt_pkg::in_t     req,
  input  logic [23:0]        timeout_ticks,
  input  logic [15:0]        fail_word,
  output dsabt_pkg::out_t    res
);

  logic [3:0]  phase_r, phase_nxt;
  logic [4:0]  bit_cnt_r, bit_cnt_nxt;
  logic [15:0] shift_r, shift_nxt;
  logic [23:0] tcnt_r, tcnt_nxt;
  logic [1:0]  pend_r, pend_nxt;
  logic [15:0] last_r, last_nxt;
  logic [5:0]  drive_r, drive_nxt;   // de, dl, se, sl, ae, al

  logic        met;
  logic        expired;
  logic        done;
  logic [1:0]  fin;
  logic [23:0] tcnt_inc;
  logic [4:0]  bit_cnt_inc;
  logic [15:0] cur_mask;
  logic [15:0] inc_mask;

  assign tcnt_inc    = tcnt_r + 24'd1;
  assign bit_cnt_inc = bit_cnt_r + 5'd1;
  assign cur_mask    = dsabt_pkg::WORD_MSB >> bit_cnt_r[3:0];
  assign inc_mask    = dsabt_pkg::WORD_MSB >> bit_cnt_inc[3:0];

  // Select the awaited line level for the current phase
  always_comb begin
    expired = 1'b0;
    case (phase_r)
      dsabt_pkg::PH_R_SYNC:  met = req.data_pin;
      dsabt_pkg::PH_R_BFALL: met = !req.strobe_pin;
      dsabt_pkg::PH_R_BRISE: met = req.strobe_pin;
      dsabt_pkg::PH_R_AFALL: met = !req.ack_pin;
      dsabt_pkg::PH_R_ARISE: met = req.ack_pin;
      dsabt_pkg::PH_T_SFALL: met = !req.ack_pin;
      dsabt_pkg::PH_T_SRISE: met = req.ack_pin;
      dsabt_pkg::PH_T_BFALL: met = !req.ack_pin;
      dsabt_pkg::PH_T_BRISE: met = req.ack_pin;
      dsabt_pkg::PH_T_AFALL: met = !req.strobe_pin;
      dsabt_pkg::PH_T_ARISE: met = req.strobe_pin;
      default: begin
        met     = 1'b0;
        expired = 1'b1;
      end
    endcase
  end

  // Next state for one tick
  always_comb begin
    phase_nxt   = phase_r;
    bit_cnt_nxt = bit_cnt_r;
    shift_nxt   = shift_r;
    tcnt_nxt    = tcnt_r;
    pend_nxt    = pend_r;
    last_nxt    = last_r;
    drive_nxt   = drive_r;
    done        = 1'b0;
    fin         = dsabt_pkg::ST_OK;

    if (phase_r == dsabt_pkg::PH_IDLE) begin
      // Start a transfer; lines are not evaluated on the start tick
      if (req.action == dsabt_pkg::ACT_RX) begin
        last_nxt     = fail_word;
        shift_nxt    = '0;
        bit_cnt_nxt  = '0;
        tcnt_nxt     = '0;
        drive_nxt[1] = 1'b1;
        drive_nxt[0] = 1'b0;
        phase_nxt    = dsabt_pkg::PH_R_SYNC;
      end else if (req.action == dsabt_pkg::ACT_TX) begin
        shift_nxt    = req.tx_message;
        bit_cnt_nxt  = '0;
        tcnt_nxt     = '0;
        drive_nxt[5] = 1'b1;
        drive_nxt[4] = 1'b0;
        phase_nxt    = dsabt_pkg::PH_T_SFALL;
      end
    end else if (expired) begin
      done = 1'b1;
      fin  = dsabt_pkg::ST_TIMEOUT;
    end else if (!met) begin
      // Count an unsatisfied tick and end on timeout
      tcnt_nxt = tcnt_inc;
      if (tcnt_inc >= timeout_ticks) begin
        done = 1'b1;
        fin  = dsabt_pkg::ST_TIMEOUT;
      end
    end else begin
      case (phase_r)
        dsabt_pkg::PH_R_SYNC: begin
          drive_nxt[0] = 1'b1;
          tcnt_nxt     = '0;
          phase_nxt    = dsabt_pkg::PH_R_BFALL;
        end
        dsabt_pkg::PH_R_BFALL: begin
          if (req.data_pin) begin
            shift_nxt = shift_r | cur_mask;
          end
          drive_nxt[0] = 1'b0;
          phase_nxt    = dsabt_pkg::PH_R_BRISE;
        end
        dsabt_pkg::PH_R_BRISE: begin
          drive_nxt[0] = 1'b1;
          bit_cnt_nxt  = bit_cnt_inc;
          if (bit_cnt_inc >= 5'd16) begin
            drive_nxt = 6'b111101;
            tcnt_nxt  = '0;
            phase_nxt = dsabt_pkg::PH_R_AFALL;
          end else begin
            phase_nxt = dsabt_pkg::PH_R_BFALL;
          end
        end
        dsabt_pkg::PH_R_AFALL: begin
          drive_nxt[2] = 1'b0;
          phase_nxt    = dsabt_pkg::PH_R_ARISE;
        end
        dsabt_pkg::PH_R_ARISE: begin
          last_nxt = shift_r;
          done     = 1'b1;
        end
        dsabt_pkg::PH_T_SFALL: begin
          drive_nxt[4] = 1'b1;
          phase_nxt    = dsabt_pkg::PH_T_SRISE;
        end
        dsabt_pkg::PH_T_SRISE: begin
          tcnt_nxt     = '0;
          drive_nxt[3] = 1'b1;
          drive_nxt[2] = 1'b0;
          drive_nxt[4] = |(shift_r & cur_mask);
          phase_nxt    = dsabt_pkg::PH_T_BFALL;
        end
        dsabt_pkg::PH_T_BFALL: begin
          drive_nxt[2] = 1'b1;
          drive_nxt[4] = 1'b1;
          phase_nxt    = dsabt_pkg::PH_T_BRISE;
        end
        dsabt_pkg::PH_T_BRISE: begin
          bit_cnt_nxt = bit_cnt_inc;
          if (bit_cnt_inc >= 5'd16) begin
            drive_nxt = 6'b010110;
            tcnt_nxt  = '0;
            phase_nxt = dsabt_pkg::PH_T_AFALL;
          end else begin
            drive_nxt[4] = |(shift_r & inc_mask);
            drive_nxt[2] = 1'b0;
            phase_nxt    = dsabt_pkg::PH_T_BFALL;
          end
        end
        dsabt_pkg::PH_T_AFALL: begin
          pend_nxt     = req.data_pin ? dsabt_pkg::ST_OK : dsabt_pkg::ST_ERR;
          drive_nxt[0] = 1'b1;
          phase_nxt    = dsabt_pkg::PH_T_ARISE;
        end
        default: begin
          done = 1'b1;
          fin  = pend_r;
        end
      endcase
    end

    // Release all lines when a transfer ends
    if (done) begin
      phase_nxt = dsabt_pkg::PH_IDLE;
      drive_nxt = 6'b010101;
    end
  end

  // Result shows the state after this tick
  always_comb begin
    res.data_enable   = drive_nxt[5];
    res.data_level    = drive_nxt[4];
    res.strobe_enable = drive_nxt[3];
    res.strobe_level  = drive_nxt[2];
    res.ack_enable    = drive_nxt[1];
    res.ack_level     = drive_nxt[0];
    res.busy_res      = (phase_nxt != dsabt_pkg::PH_IDLE);
    res.done_res      = done;
    res.status        = done ? fin : dsabt_pkg::ST_OK;
    res.rx_message    = last_nxt;
  end

  // Advance state on each accepted request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= dsabt_pkg::PH_IDLE;
      bit_cnt_r <= '0;
      shift_r   <= '0;
      tcnt_r    <= '0;
      pend_r    <= dsabt_pkg::ST_OK;
      last_r    <= dsabt_pkg::INVALID_RESET;
      drive_r   <= 6'b010101;
    end else if (step) begin
      phase_r   <= phase_nxt;
      bit_cnt_r <= bit_cnt_nxt;
      shift_r   <= shift_nxt;
      tcnt_r    <= tcnt_nxt;
      pend_r    <= pend_nxt;
      last_r    <= last_nxt;
      drive_r   <= drive_nxt;
    end
  end

endmodule

### src/dsa_bus_word_transceiver.sv
// Top level of the data/strobe/acknowledge bus word transceiver.
// Depends on dsabt_pkg and dsabt_fsm; holds configuration and the result register.
//
// Usage: each request on the in_ channel is one tick of sampled DATA, STROBE
// and ACK levels plus an action (tick only, start receive, start transmit).
// Every request yields exactly one result on the out_ channel: the line
// drive to apply, busy/done flags, the finished transfer's status and the
// last received word (or the invalid word after a failed receive).
// The result is registered and valid in the cycle after accept; throughput
// is one request per cycle while results are taken, set by the phase sequencer
// feeding the result register. The sequencer state updates at the accept
// edge, so the next request is taken while the previous result is offered.
// When the receiver stalls, the result register holds and in_ready drops
// until the held result is taken; in_ready is high again in the cycle the
// result is accepted. Reset (rst_n low, synchronous) returns the bus to idle
// with all lines released, timeout_ticks to 250 and the failed-receive word
// to 0xFFFF. Configuration writes through cfg_ take effect at the next edge.
module dsa_bus_word_transceiver (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  dsabt_pkg::in_t                     in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output dsabt_pkg::out_t                    out_data,
  input  logic                               cfg_we,
  input  logic [dsabt_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dsabt_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  logic [23:0]     timeout_ticks_r;
  logic [15:0]     fail_word_r;
  logic            out_valid_r;
  dsabt_pkg::out_t out_r;
  dsabt_pkg::out_t res;
  logic            step;

  assign in_ready  = !out_valid_r || out_ready;
  assign step      = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_ticks_r <= dsabt_pkg::TIMEOUT_RESET;
      fail_word_r     <= dsabt_pkg::INVALID_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        dsabt_pkg::CFG_TIMEOUT_TICKS: timeout_ticks_r <= cfg_wdata[23:0];
        dsabt_pkg::CFG_FAIL_WORD:     fail_word_r     <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  dsabt_fsm u_fsm (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (step),
    .req           (in_data),
    .timeout_ticks (timeout_ticks_r),
    .fail_word     (fail_word_r),
    .res           (res)
  );

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_r <= res;
    end
  end

endmodule

### src/dsabt_checker.sv
// Port-level checks for the bus word transceiver, bound to the top level.
// Depends on dsabt_pkg; observes ports only.
module dsabt_checker (
  input logic            clk,
  input logic            rst_n,
  input logic            out_valid,
  input logic            out_ready,
  input dsabt_pkg::out_t out_data
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Finished transfer is never still busy
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.done_res |-> !out_data.busy_res)
    else $error("done with busy set");

  // Status reads ok unless a transfer finishes
  a_status_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.done_res |-> out_data.status == dsabt_pkg::ST_OK)
    else $error("status set without done");

  // Idle bus releases every line high
  a_idle_release: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.busy_res |->
      !out_data.data_enable && !out_data.strobe_enable && !out_data.ack_enable &&
      out_data.data_level && out_data.strobe_level && out_data.ack_level)
    else $error("line driven while idle");

endmodule

bind dsa_bus_word_transceiver dsabt_checker u_dsabt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

### bench/dsa_bus_word_transceiver_test.sv
// Self-checking bench for the data/strobe/acknowledge bus word transceiver.
// Depends on dsabt_pkg and dsa_bus_word_transceiver; predicts every tick
// result in-line and compares them in order on the out_ channel.
`timescale 1ns / 1ps

module dsa_bus_word_transceiver_test;

  // Action code with no meaning to the block: behaves as a plain tick
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  logic                             clk;
  logic                             rst_n;
  logic                             in_valid;
  logic                             in_ready;
  dsabt_pkg::in_t                   in_data;
  logic                             out_valid;
  logic                             out_ready;
  dsabt_pkg::out_t                  out_data;
  logic                             cfg_we;
  logic [dsabt_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [dsabt_pkg::CFG_DATA_W-1:0] cfg_wdata;

  // Bus engine mirror: protocol state and register copies
  logic [3:0]  ph = dsabt_pkg::PH_IDLE;
  logic [4:0]  bit_cnt = '0;
  logic [15:0] shift_w = '0;
  logic [23:0] to_cnt = '0;
  logic [1:0]  pend_st = dsabt_pkg::ST_OK;
  logic [15:0] last_word = dsabt_pkg::INVALID_RESET;
  logic        de = 1'b0, dl = 1'b1, se = 1'b0, sl = 1'b1, ae = 1'b0, al = 1'b1;
  logic [23:0] timeout_lim = dsabt_pkg::TIMEOUT_RESET;
  logic [15:0] invalid_word = dsabt_pkg::INVALID_RESET;

  dsabt_pkg::out_t bus_reports_q[$];
  int   errors = 0;
  bit   gaps_on = 1'b1;
  int   long_hold = 0;

  dsa_bus_word_transceiver uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the handshake hangs
  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

  // Count one unmet wait tick; -1 once the phase budget is used up
  function automatic int wait_level(input bit met);
    if (met) return 1;
    to_cnt = to_cnt + 24'd1;
    return (to_cnt >= timeout_lim) ? -1 : 0;
  endfunction

  // Advance the mirrored bus engine by one tick and return the line report
  function automatic dsabt_pkg::out_t step_bus_engine(input dsabt_pkg::in_t req);
    dsabt_pkg::out_t rsp;
    bit              fin;
    logic [1:0]      fin_st;
    int              w;
    fin = 1'b0;
    fin_st = dsabt_pkg::ST_OK;
    w = 0;
    if (ph == dsabt_pkg::PH_IDLE) begin
      if (req.action == dsabt_pkg::ACT_RX) begin
        last_word = invalid_word;
        shift_w = '0; bit_cnt = '0; to_cnt = '0;
        ae = 1'b1; al = 1'b0;
        ph = dsabt_pkg::PH_R_SYNC;
      end else if (req.action == dsabt_pkg::ACT_TX) begin
        shift_w = req.tx_message; bit_cnt = '0; to_cnt = '0;
        de = 1'b1; dl = 1'b0;
        ph = dsabt_pkg::PH_T_SFALL;
      end
    end else begin
      case (ph)
        dsabt_pkg::PH_R_SYNC:  w = wait_level(req.data_pin);
        dsabt_pkg::PH_R_BFALL: w = wait_level(!req.strobe_pin);
        dsabt_pkg::PH_R_BRISE: w = wait_level(req.strobe_pin);
        dsabt_pkg::PH_R_AFALL: w = wait_level(!req.ack_pin);
        dsabt_pkg::PH_R_ARISE: w = wait_level(req.ack_pin);
        dsabt_pkg::PH_T_SFALL: w = wait_level(!req.ack_pin);
        dsabt_pkg::PH_T_SRISE: w = wait_level(req.ack_pin);
        dsabt_pkg::PH_T_BFALL: w = wait_level(!req.ack_pin);
        dsabt_pkg::PH_T_BRISE: w = wait_level(req.ack_pin);
        dsabt_pkg::PH_T_AFALL: w = wait_level(!req.strobe_pin);
        dsabt_pkg::PH_T_ARISE: w = wait_level(req.strobe_pin);
        default:               w = -1;
      endcase
      if (w < 0) begin
        fin = 1'b1;
        fin_st = dsabt_pkg::ST_TIMEOUT;
      end else if (w > 0) begin
        case (ph)
          dsabt_pkg::PH_R_SYNC: begin
            al = 1'b1; to_cnt = '0; ph = dsabt_pkg::PH_R_BFALL;
          end
          dsabt_pkg::PH_R_BFALL: begin
            if (req.data_pin) shift_w = shift_w | (dsabt_pkg::WORD_MSB >> bit_cnt[3:0]);
            al = 1'b0; ph = dsabt_pkg::PH_R_BRISE;
          end
          dsabt_pkg::PH_R_BRISE: begin
            al = 1'b1;
            bit_cnt = bit_cnt + 5'd1;
            if (bit_cnt >= 5'd16) begin
              de = 1'b1; dl = 1'b1; se = 1'b1; sl = 1'b1; ae = 1'b0; al = 1'b1;
              to_cnt = '0; ph = dsabt_pkg::PH_R_AFALL;
            end else begin
              ph = dsabt_pkg::PH_R_BFALL;
            end
          end
          dsabt_pkg::PH_R_AFALL: begin
            sl = 1'b0; ph = dsabt_pkg::PH_R_ARISE;
          end
          dsabt_pkg::PH_R_ARISE: begin
            last_word = shift_w;
            fin = 1'b1; fin_st = dsabt_pkg::ST_OK;
          end
          dsabt_pkg::PH_T_SFALL: begin
            dl = 1'b1; ph = dsabt_pkg::PH_T_SRISE;
          end
          dsabt_pkg::PH_T_SRISE: begin
            to_cnt = '0; se = 1'b1; sl = 1'b0;
            dl = |(shift_w & (dsabt_pkg::WORD_MSB >> bit_cnt[3:0]));
            ph = dsabt_pkg::PH_T_BFALL;
          end
          dsabt_pkg::PH_T_BFALL: begin
            sl = 1'b1; dl = 1'b1; ph = dsabt_pkg::PH_T_BRISE;
          end
          dsabt_pkg::PH_T_BRISE: begin
            bit_cnt = bit_cnt + 5'd1;
            if (bit_cnt >= 5'd16) begin
              se = 1'b0; sl = 1'b1; de = 1'b0; dl = 1'b1; ae = 1'b1; al = 1'b0;
              to_cnt = '0; ph = dsabt_pkg::PH_T_AFALL;
            end else begin
              dl = |(shift_w & (dsabt_pkg::WORD_MSB >> bit_cnt[3:0]));
              sl = 1'b0; ph = dsabt_pkg::PH_T_BFALL;
            end
          end
          dsabt_pkg::PH_T_AFALL: begin
            pend_st = req.data_pin ? dsabt_pkg::ST_OK : dsabt_pkg::ST_ERR;
            al = 1'b1; ph = dsabt_pkg::PH_T_ARISE;
          end
          default: begin
            fin = 1'b1; fin_st = pend_st;
          end
        endcase
      end
      // Release every line once the transfer ends
      if (fin) begin
        ph = dsabt_pkg::PH_IDLE;
        de = 1'b0; se = 1'b0; ae = 1'b0;
        dl = 1'b1; sl = 1'b1; al = 1'b1;
      end
    end
    rsp.data_enable   = de;
    rsp.data_level    = dl;
    rsp.strobe_enable = se;
    rsp.strobe_level  = sl;
    rsp.ack_enable    = ae;
    rsp.ack_level     = al;
    rsp.busy_res      = (ph != dsabt_pkg::PH_IDLE);
    rsp.done_res      = fin;
    rsp.status        = fin ? fin_st : dsabt_pkg::ST_OK;
    rsp.rx_message    = last_word;
    return rsp;
  endfunction

  function automatic dsabt_pkg::in_t make_req(input logic [1:0] act,
                                              input logic [15:0] word,
                                              input bit d, input bit s, input bit a);
    dsabt_pkg::in_t req;
    req.action = act;
    req.tx_message = word;
    req.data_pin = d;
    req.strobe_pin = s;
    req.ack_pin = a;
    return req;
  endfunction

  // Play the bus partner: meet the awaited level with the given odds
  function automatic dsabt_pkg::in_t partner_tick(input int unsigned meet_pct);
    dsabt_pkg::in_t req;
    bit             meet;
    req = make_req(dsabt_pkg::ACT_TICK, 16'($urandom), 1'($urandom), 1'($urandom),
                   1'($urandom));
    if ($urandom_range(0, 9) == 0) req.action = 2'($urandom_range(0, 3));
    meet = ($urandom_range(0, 99) < meet_pct);
    case (ph)
      dsabt_pkg::PH_R_SYNC:  req.data_pin = meet;
      dsabt_pkg::PH_R_BFALL: req.strobe_pin = !meet;
      dsabt_pkg::PH_R_BRISE: req.strobe_pin = meet;
      dsabt_pkg::PH_R_AFALL: req.ack_pin = !meet;
      dsabt_pkg::PH_R_ARISE: req.ack_pin = meet;
      dsabt_pkg::PH_T_SFALL, dsabt_pkg::PH_T_BFALL: req.ack_pin = !meet;
      dsabt_pkg::PH_T_SRISE, dsabt_pkg::PH_T_BRISE: req.ack_pin = meet;
      dsabt_pkg::PH_T_AFALL: req.strobe_pin = !meet;
      dsabt_pkg::PH_T_ARISE: req.strobe_pin = meet;
      default: ;
    endcase
    return req;
  endfunction

  // Offer one request, hold it until taken, then log its predicted report
  task automatic send_tick(input dsabt_pkg::in_t req);
    @(negedge clk);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bus_reports_q.push_back(step_bus_engine(req));
  endtask

  // Write a register once the block is idle and every report is in
  task automatic write_reg(input logic [dsabt_pkg::CFG_IDX_W-1:0] idx,
                           input logic [23:0] value);
    @(negedge clk);
    in_valid <= 1'b0;
    while (bus_reports_q.size() != 0) @(posedge clk);
    repeat (2) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == dsabt_pkg::CFG_TIMEOUT_TICKS) timeout_lim = value;
    else invalid_word = value[15:0];
  endtask

  // Start one transfer and follow it to the end; force progress if it drags
  task automatic run_transfer(input logic [1:0] act, input int unsigned meet_pct);
    int n;
    n = 0;
    send_tick(make_req(act, 16'($urandom), 1'($urandom), 1'($urandom), 1'($urandom)));
    while (ph != dsabt_pkg::PH_IDLE) begin
      send_tick(partner_tick((n < 200) ? meet_pct : 100));
      n++;
    end
  endtask

  // Transfers of random direction, with idle noise ticks in between
  task automatic run_transfers(input int count, input int unsigned meet_pct);
    repeat (count) begin
      repeat ($urandom_range(0, 3))
        send_tick(make_req($urandom_range(0, 1) ? dsabt_pkg::ACT_TICK : ACT_UNUSED,
                           16'($urandom), 1'($urandom), 1'($urandom), 1'($urandom)));
      run_transfer($urandom_range(0, 1) ? dsabt_pkg::ACT_RX : dsabt_pkg::ACT_TX,
                   meet_pct);
    end
  endtask

  task automatic test_idle_ticks();
    send_tick(make_req(dsabt_pkg::ACT_TICK, 16'h0000, 1'b0, 1'b0, 1'b0));
    send_tick(make_req(dsabt_pkg::ACT_TICK, 16'hFFFF, 1'b1, 1'b1, 1'b1));
    send_tick(make_req(ACT_UNUSED, 16'hFFFF, 1'b1, 1'b0, 1'b1));
    send_tick(make_req(ACT_UNUSED, 16'h0000, 1'b0, 1'b1, 1'b0));
  endtask

  // One-tick budget: every unmet wait ends the transfer at once
  task automatic test_directed_timeouts();
    write_reg(dsabt_pkg::CFG_TIMEOUT_TICKS, 24'd1);
    write_reg(dsabt_pkg::CFG_FAIL_WORD, 24'h000000);
    // receive: sync, one bit, a start while busy, then a stalled strobe
    send_tick(make_req(dsabt_pkg::ACT_RX, 16'h0000, 1'b1, 1'b1, 1'b1));
    send_tick(make_req(dsabt_pkg::ACT_TICK, 16'h0000, 1'b1, 1'b1, 1'b1));
    send_tick(make_req(dsabt_pkg::ACT_TICK, 16'h0000, 1'b1, 1'b0, 1'b0));
    send_tick(make_req(dsabt_pkg::ACT_TX, 16'hFFFF, 1'b0, 1'b1, 1'b1));
    send_tick(make_req(dsabt_pkg::ACT_TICK, 16'h0000, 1'b0, 1'b1, 1'b0));
    // receive with no sync
    send_tick(make_req(dsabt_pkg::ACT_RX, 16'h0000, 1'b0, 1'b0, 1'b0));
    send_tick(make_req(dsabt_pkg::ACT_TICK, 16'h0000, 1'b0, 1'b0, 1'b0));
    // transmit stalled in sync rise
    send_tick(make_req(dsabt_pkg::ACT_TX, 16'hFFFF, 1'b1, 1'b1, 1'b1));
    send_tick(make_req(dsabt_pkg::ACT_TICK, 16'h0000, 1'b1, 1'b1, 1'b0));
    send_tick(make_req(dsabt_pkg::ACT_TICK, 16'h0000, 1'b1, 1'b1, 1'b0));
    // transmit stalled on the first bit
    send_tick(make_req(dsabt_pkg::ACT_TX, 16'h0000, 1'b0, 1'b0, 1'b0));
    send_tick(make_req(dsabt_pkg::ACT_TICK, 16'hFFFF, 1'b0, 1'b0, 1'b0));
    send_tick(make_req(dsabt_pkg::ACT_TICK, 16'hFFFF, 1'b0, 1'b0, 1'b1));
    send_tick(make_req(dsabt_pkg::ACT_TICK, 16'hFFFF, 1'b0, 1'b0, 1'b1));
  endtask

  task automatic test_nominal_transfers();
    write_reg(dsabt_pkg::CFG_TIMEOUT_TICKS, 24'd250);
    write_reg(dsabt_pkg::CFG_FAIL_WORD, {8'h00, 16'($urandom)});
    run_transfers(3, 85);
  endtask

  task automatic test_short_timeout();
    write_reg(dsabt_pkg::CFG_TIMEOUT_TICKS, 24'd3);
    write_reg(dsabt_pkg::CFG_FAIL_WORD, {8'h00, 16'($urandom)});
    run_transfers(4, 70);
  endtask

  task automatic test_long_timeout();
    write_reg(dsabt_pkg::CFG_TIMEOUT_TICKS, 24'hFFFFFF);
    write_reg(dsabt_pkg::CFG_FAIL_WORD, 24'h00FFFF);
    run_transfers(3, 80);
  endtask

  // Hold the result side off while requests keep coming
  task automatic test_backpressure();
    write_reg(dsabt_pkg::CFG_TIMEOUT_TICKS, 24'd250);
    long_hold = 40;
    run_transfer(dsabt_pkg::ACT_TX, 90);
    long_hold = 60;
    run_transfer(dsabt_pkg::ACT_RX, 90);
  endtask

  task automatic test_steady_stream();
    write_reg(dsabt_pkg::CFG_TIMEOUT_TICKS, 24'd2);
    gaps_on = 1'b0;
    run_transfers(3, 90);
  endtask

  // Result side: random stall bursts, plus a long hold when one is asked
  initial begin : result_ready
    int stall_left;
    stall_left = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold > 0) begin
        stall_left = long_hold;
        long_hold = 0;
      end else if (stall_left == 0 && gaps_on && $urandom_range(0, 3) == 0) begin
        stall_left = $urandom_range(1, 5);
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
    end
  endtask

  // Compare each result against the oldest predicted report
  always @(posedge clk) begin : report_check
    dsabt_pkg::out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (bus_reports_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, got %p", $time, out_data);
      end else begin
        want = bus_reports_q.pop_front();
        check_field("data_enable", 16'(want.data_enable), 16'(out_data.data_enable));
        check_field("data_level", 16'(want.data_level), 16'(out_data.data_level));
        check_field("strobe_enable", 16'(want.strobe_enable),
                    16'(out_data.strobe_enable));
        check_field("strobe_level", 16'(want.strobe_level), 16'(out_data.strobe_level));
        check_field("ack_enable", 16'(want.ack_enable), 16'(out_data.ack_enable));
        check_field("ack_level", 16'(want.ack_level), 16'(out_data.ack_level));
        check_field("busy_res", 16'(want.busy_res), 16'(out_data.busy_res));
        check_field("done_res", 16'(want.done_res), 16'(out_data.done_res));
        check_field("status", 16'(want.status), 16'(out_data.status));
        check_field("rx_message", want.rx_message, out_data.rx_message);
      end
    end
  end

  initial begin : run_tests
    int n;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    test_idle_ticks();
    test_directed_timeouts();
    test_nominal_transfers();
    test_short_timeout();
    test_long_timeout();
    test_backpressure();
    test_steady_stream();

    // Drain the remaining reports, then allow the pipeline to settle
    @(negedge clk);
    in_valid <= 1'b0;
    n = 0;
    while (bus_reports_q.size() != 0 && n < 2000) begin
      @(posedge clk);
      n++;
    end
    if (bus_reports_q.size() != 0) begin
      errors++;
      $display("%0t: %0d results never arrived, expected %p", $time,
               bus_reports_q.size(), bus_reports_q[0]);
    end
    repeat (4) @(posedge clk);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
